### rtl/reading_buffer_hex_framer_top_macros.svh
// Assertion macros for the reading buffer hex framer.
// Used by the top level; the macros expect clk and rst in scope.
`ifndef READING_BUFFER_HEX_FRAMER_TOP_MACROS_SVH
`define READING_BUFFER_HEX_FRAMER_TOP_MACROS_SVH

// same-cycle implication
`define RBHF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbhf assertion failed");

// next-cycle implication
`define RBHF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbhf assertion failed");

`endif

### rtl/rbhf_pkg.sv
// Shared types, constants and the hex digit helper for the reading buffer framer.
// No dependencies.
`timescale 1ns / 1ps

package rbhf_pkg;

  localparam int RING_DEPTH_DEF = 5;
  localparam int NIB_COUNT = 14;
  localparam int STEPS_PER_READING = 8;
  localparam logic [2:0] STEP_LAST = 3'(STEPS_PER_READING - 1);

  localparam logic [7:0] CH_START = 8'd35;
  localparam logic [7:0] CH_END = 8'd59;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;
  localparam logic [7:0] HEX_DIGIT_OFS = 8'd48;

  localparam logic [1:0] ACT_STORE = 2'd0;
  localparam logic [1:0] ACT_DRAIN = 2'd1;
  localparam logic [1:0] ACT_STATUS = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_STAT
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  sensor_id;
    logic [7:0]  channel_id;
    logic [23:0] reading_value;
    logic [31:0] time_stamp;
    logic [7:0]  status_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       second_valid;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [7:0]  sensor_id;
    logic [7:0]  channel_id;
    logic [23:0] reading_value;
    logic [31:0] time_stamp;
  } reading_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    return (nib > 4'd9) ? wide + HEX_ALPHA_OFS : wide + HEX_DIGIT_OFS;
  endfunction

endpackage

### rtl/rbhf_ring.sv
// Ring of readings with drop-oldest on a full store and pop from the head.
// Depends on rbhf_pkg.
`timescale 1ns / 1ps

module rbhf_ring #(
  parameter int DEPTH = rbhf_pkg::RING_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              pop,
  input  rbhf_pkg::reading_t wr,
  output rbhf_pkg::reading_t head,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;

  rbhf_pkg::reading_t mem [DEPTH];

  logic [PTR_W-1:0] oldest;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] oldest_inc;
  logic [SUM_W-1:0] wsum;
  logic [SUM_W-1:0] wslot;
  logic [PTR_W-1:0] slot;
  logic             full;

  assign full = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign oldest_inc = (oldest == PTR_W'(DEPTH - 1)) ? '0 : oldest + PTR_W'(1);
  assign wsum = SUM_W'(oldest) + SUM_W'(count);
  assign wslot = (wsum >= SUM_W'(DEPTH)) ? wsum - SUM_W'(DEPTH) : wsum;
  assign slot = wslot[PTR_W-1:0];
  assign head = mem[oldest];

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest <= '0;
      count <= '0;
    end else if (push) begin
      if (full) begin
        oldest <= oldest_inc;
      end else begin
        count <= count + CNT_W'(1);
      end
    end else if (pop) begin
      oldest <= oldest_inc;
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[slot] <= wr;
    end
  end

endmodule

### rtl/rbhf_byte_pair.sv
// Shared framing unit: picks two frame bytes of one reading for a given step
// and turns nibbles into uppercase hex ASCII. Depends on rbhf_pkg.
`timescale 1ns / 1ps

module rbhf_byte_pair (
  input  rbhf_pkg::reading_t rd,
  input  logic [2:0]         step,
  input  logic [7:0]         tail,
  output logic [7:0]         first_byte,
  output logic [7:0]         second_byte
);

  logic [55:0] digits;
  logic [3:0]  nib [rbhf_pkg::NIB_COUNT];
  logic [3:0]  fi;
  logic [3:0]  si;

  assign digits = {rd.reading_value, rd.time_stamp};

  always_comb begin
    for (int k = 0; k < rbhf_pkg::NIB_COUNT; k++) begin
      nib[k] = digits[55 - 4 * k -: 4];
    end
  end

  // step 0 starts with the raw channel byte, step 7 ends on the next frame byte
  assign fi = (step == 3'd0) ? 4'd0 : {step, 1'b0} - 4'd1;
  assign si = (step == rbhf_pkg::STEP_LAST) ? 4'd0 : {step, 1'b0};

  assign first_byte = (step == 3'd0) ? rd.channel_id : rbhf_pkg::hex_char(nib[fi]);
  assign second_byte = (step == rbhf_pkg::STEP_LAST) ? tail : rbhf_pkg::hex_char(nib[si]);

endmodule

### rtl/reading_buffer_hex_framer_top.sv
// Reading buffer with hex ASCII framing. A store command yields no beat; it
// drops the oldest reading when the ring is full. A drain command yields
// 1 + 8*N result beats for N held readings, one beat per cycle on consecutive
// cycles starting the cycle after start is taken; busy stays high while the
// sequencer steps the shared nibble-to-ASCII pair unit once per beat. A status
// command yields 3 beats. The receiver cannot stall: every beat is shown on
// result for exactly one cycle with strobe high. Depends on rbhf_pkg,
// rbhf_ring, rbhf_byte_pair.
`timescale 1ns / 1ps
`include "reading_buffer_hex_framer_top_macros.svh"

module reading_buffer_hex_framer_top #(
  parameter int RING_DEPTH = rbhf_pkg::RING_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rbhf_pkg::item_t   item,
  output logic              busy,
  output logic              strobe,
  output rbhf_pkg::result_t result
);

  rbhf_pkg::state_t   state;
  rbhf_pkg::state_t   state_next;
  logic [2:0]         step;
  logic [2:0]         step_next;
  rbhf_pkg::reading_t work;
  rbhf_pkg::reading_t work_next;
  logic [7:0]         stat_channel;
  logic [7:0]         stat_channel_next;
  logic [7:0]         stat_byte;
  logic [7:0]         stat_byte_next;
  rbhf_pkg::result_t  result_next;
  logic               strobe_next;

  logic               accept;
  logic               push;
  logic               pop;
  rbhf_pkg::reading_t wr;
  rbhf_pkg::reading_t head;
  logic               empty;
  logic [7:0]         tail;
  logic [7:0]         pair_first;
  logic [7:0]         pair_second;

  assign busy = (state != rbhf_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign tail = empty ? rbhf_pkg::CH_END : head.sensor_id;

  assign wr.sensor_id = item.sensor_id;
  assign wr.channel_id = item.channel_id;
  assign wr.reading_value = item.reading_value;
  assign wr.time_stamp = item.time_stamp;

  rbhf_ring #(
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .wr   (wr),
    .head (head),
    .empty(empty)
  );

  rbhf_byte_pair u_pair (
    .rd         (work),
    .step       (step),
    .tail       (tail),
    .first_byte (pair_first),
    .second_byte(pair_second)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      rbhf_pkg::ST_IDLE: begin
        if (accept && item.action == rbhf_pkg::ACT_DRAIN && !empty) begin
          state_next = rbhf_pkg::ST_DRAIN;
        end else if (accept && item.action == rbhf_pkg::ACT_STATUS) begin
          state_next = rbhf_pkg::ST_STAT;
        end
      end
      rbhf_pkg::ST_DRAIN: begin
        if (step == rbhf_pkg::STEP_LAST && empty) begin
          state_next = rbhf_pkg::ST_IDLE;
        end
      end
      rbhf_pkg::ST_STAT: begin
        if (step != 3'd0) begin
          state_next = rbhf_pkg::ST_IDLE;
        end
      end
      default: state_next = rbhf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    result_next = result;
    strobe_next = 1'b0;
    step_next = step;
    work_next = work;
    stat_channel_next = stat_channel;
    stat_byte_next = stat_byte;
    push = 1'b0;
    pop = 1'b0;
    unique case (state)
      rbhf_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (item.action)
            rbhf_pkg::ACT_STORE: begin
              push = 1'b1;
            end
            rbhf_pkg::ACT_DRAIN: begin
              strobe_next = 1'b1;
              step_next = 3'd0;
              if (empty) begin
                result_next = '{rbhf_pkg::CH_START, rbhf_pkg::CH_END, 1'b1, 1'b1};
              end else begin
                result_next = '{rbhf_pkg::CH_START, head.sensor_id, 1'b1, 1'b0};
                pop = 1'b1;
                work_next = head;
              end
            end
            rbhf_pkg::ACT_STATUS: begin
              strobe_next = 1'b1;
              step_next = 3'd0;
              result_next = '{rbhf_pkg::CH_START, item.sensor_id, 1'b1, 1'b0};
              stat_channel_next = item.channel_id;
              stat_byte_next = item.status_byte;
            end
            default: ;
          endcase
        end
      end
      rbhf_pkg::ST_DRAIN: begin
        strobe_next = 1'b1;
        result_next = '{pair_first, pair_second, 1'b1,
                        (step == rbhf_pkg::STEP_LAST) && empty};
        if (step == rbhf_pkg::STEP_LAST) begin
          step_next = 3'd0;
          if (!empty) begin
            pop = 1'b1;
            work_next = head;
          end
        end else begin
          step_next = step + 3'd1;
        end
      end
      rbhf_pkg::ST_STAT: begin
        strobe_next = 1'b1;
        if (step == 3'd0) begin
          result_next = '{stat_channel, stat_byte, 1'b1, 1'b0};
          step_next = 3'd1;
        end else begin
          result_next = '{rbhf_pkg::CH_END, 8'h00, 1'b0, 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbhf_pkg::ST_IDLE;
      strobe <= 1'b0;
      step <= 3'd0;
    end else begin
      state <= state_next;
      strobe <= strobe_next;
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    work <= work_next;
    stat_channel <= stat_channel_next;
    stat_byte <= stat_byte_next;
  end

  `RBHF_ASSERT_IMP(a_last_idle, strobe && result.last, !busy)
  `RBHF_ASSERT_IMP(a_busy_beats, busy, strobe)
  `RBHF_ASSERT_NXT(a_drain_beat, start && !busy && item.action == rbhf_pkg::ACT_DRAIN, strobe)
  `RBHF_ASSERT_IMP(a_odd_tail, strobe && !result.second_valid,
                   result.last && result.second_byte == 8'h00)

endmodule

### tb/reading_buffer_hex_framer_top_tb.sv
// Self-checking testbench for reading_buffer_hex_framer_top: predicts every frame beat
// from a shadow copy of the reading ring and compares it with the strobed result.
// Depends on rbhf_pkg and the RTL of the top level.
`timescale 1ns / 1ps

module reading_buffer_hex_framer_top_tb;
  import rbhf_pkg::*;

  localparam int DEPTH = RING_DEPTH_DEF;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 235;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_TAIL = 48;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  item_t item = '0;
  logic busy;
  logic strobe;
  result_t result;

  reading_buffer_hex_framer_top u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .strobe(strobe),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  item_t pending_items[$];
  result_t frame_beats_due[$];
  logic [7:0] frame_bytes[$];

  reading_t shadow_ring[DEPTH];
  logic [2:0] shadow_oldest = '0;
  logic [2:0] shadow_count = '0;

  int errors = 0;
  int beats_checked = 0;
  int stores = 0, overwrites = 0, drains = 0, full_drains = 0, status_frames = 0, ignored = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  bit steady_run = 1'b0;
  bit beat_taken = 1'b0;
  bit progress;

  task automatic push_hex(input logic [31:0] value, input int digits);
    logic [3:0] nib;
    for (int k = digits - 1; k >= 0; k--) begin
      nib = value[4*k +: 4];
      frame_bytes.push_back((nib > 4'd9) ? {4'h0, nib} + HEX_ALPHA_OFS
                                         : {4'h0, nib} + HEX_DIGIT_OFS);
    end
  endtask

  task automatic frame_for_item(input item_t it);
    int slot;
    result_t beat;
    frame_bytes.delete();
    case (it.action)
      ACT_STORE: begin
        stores++;
        if (shadow_count >= 3'(DEPTH)) begin
          shadow_oldest = 3'((int'(shadow_oldest) + 1) % DEPTH);
          shadow_count = 3'(DEPTH - 1);
          overwrites++;
        end
        slot = (int'(shadow_oldest) + int'(shadow_count)) % DEPTH;
        shadow_ring[slot] = '{it.sensor_id, it.channel_id, it.reading_value, it.time_stamp};
        shadow_count++;
      end
      ACT_DRAIN: begin
        drains++;
        if (shadow_count == 3'(DEPTH)) full_drains++;
        frame_bytes.push_back(CH_START);
        while (shadow_count != 0) begin
          slot = int'(shadow_oldest) % DEPTH;
          frame_bytes.push_back(shadow_ring[slot].sensor_id);
          frame_bytes.push_back(shadow_ring[slot].channel_id);
          push_hex({8'h00, shadow_ring[slot].reading_value}, 6);
          push_hex(shadow_ring[slot].time_stamp, 8);
          shadow_oldest = 3'((slot + 1) % DEPTH);
          shadow_count--;
        end
        frame_bytes.push_back(CH_END);
      end
      ACT_STATUS: begin
        status_frames++;
        frame_bytes.push_back(CH_START);
        frame_bytes.push_back(it.sensor_id);
        frame_bytes.push_back(it.channel_id);
        frame_bytes.push_back(it.status_byte);
        frame_bytes.push_back(CH_END);
      end
      default: ignored++;
    endcase
    for (int p = 0; p < frame_bytes.size(); p += 2) begin
      beat.first_byte = frame_bytes[p];
      beat.second_valid = (p + 1 < frame_bytes.size());
      beat.second_byte = beat.second_valid ? frame_bytes[p+1] : 8'h00;
      beat.last = (p + 2 >= frame_bytes.size());
      frame_beats_due.push_back(beat);
    end
  endtask

  // driver: one item per start, random hold-off between items
  always @(negedge clk) begin
    if (!rst) begin
      if (!start || beat_taken) begin
        beat_taken = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_items.size() != 0) begin
          item <= pending_items.pop_front();
          start <= 1'b1;
          if ($urandom_range(0, 15) == 0) steady_run = !steady_run;
          gap_left = steady_run ? 0 : $urandom_range(0, 7);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: check beats, predict accepted items, watchdog
  always @(posedge clk) begin
    if (!rst) begin
      progress = 1'b0;
      if (strobe) begin
        progress = 1'b1;
        if (frame_beats_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, actual fb=%h sb=%h sv=%b last=%b",
                   $time, result.first_byte, result.second_byte, result.second_valid,
                   result.last);
        end else begin
          beats_checked++;
          if (result.first_byte !== frame_beats_due[0].first_byte ||
              result.second_byte !== frame_beats_due[0].second_byte ||
              result.second_valid !== frame_beats_due[0].second_valid ||
              result.last !== frame_beats_due[0].last) begin
            errors++;
            $display("%0t: mismatch exp fb=%h sb=%h sv=%b last=%b act fb=%h sb=%h sv=%b last=%b",
                     $time, frame_beats_due[0].first_byte, frame_beats_due[0].second_byte,
                     frame_beats_due[0].second_valid, frame_beats_due[0].last,
                     result.first_byte, result.second_byte, result.second_valid,
                     result.last);
          end
          void'(frame_beats_due.pop_front());
        end
      end
      if (start && !busy) begin
        frame_for_item(item);
        beat_taken = 1'b1;
        progress = 1'b1;
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, %0d beats still due", $time, frame_beats_due.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic queue_item(input logic [1:0] act, input logic [7:0] sid, input logic [7:0] cid,
                            input logic [23:0] val, input logic [31:0] ts,
                            input logic [7:0] stat);
    pending_items.push_back('{act, sid, cid, val, ts, stat});
  endtask

  function automatic item_t random_item(input logic [1:0] act);
    item_t it;
    it.action = act;
    it.sensor_id = 8'($urandom);
    it.channel_id = 8'($urandom);
    it.reading_value = 24'($urandom);
    it.time_stamp = $urandom;
    it.status_byte = 8'($urandom);
    return it;
  endfunction

  initial begin
    int real_items;
    int n;
    int roll;
    real_items = 0;

    // directed: empty drain, status extremes, reading extremes, hex letters, full ring
    queue_item(ACT_DRAIN, 8'h00, 8'h00, 24'h0, 32'h0, 8'h00);
    queue_item(ACT_STATUS, 8'h00, 8'h00, 24'h0, 32'h0, 8'h00);
    queue_item(ACT_STATUS, 8'hFF, 8'hFF, 24'hFFFFFF, 32'hFFFFFFFF, 8'hFF);
    queue_item(ACT_STORE, 8'h00, 8'h00, 24'h000000, 32'h00000000, 8'hFF);
    queue_item(ACT_STORE, 8'hFF, 8'hFF, 24'hFFFFFF, 32'hFFFFFFFF, 8'h00);
    queue_item(ACT_DRAIN, 8'hFF, 8'hFF, 24'hFFFFFF, 32'hFFFFFFFF, 8'hFF);
    queue_item(ACT_STORE, 8'h01, 8'h80, 24'h0123AB, 32'h89ABCDEF, 8'h5A);
    queue_item(ACT_STORE, 8'h02, 8'h7F, 24'h456789, 32'h01234567, 8'hA5);
    queue_item(ACT_STORE, 8'h03, 8'h3C, 24'hCDEF09, 32'hFEDCBA98, 8'h00);
    queue_item(ACT_STORE, 8'h04, 8'hC3, 24'h9A0F5E, 32'h76543210, 8'h00);
    queue_item(ACT_STORE, 8'h05, 8'h55, 24'hA5A5A5, 32'h5A5A5A5A, 8'h00);
    queue_item(ACT_STORE, 8'h06, 8'hAA, 24'h5A5A5A, 32'hA5A5A5A5, 8'h00);
    queue_item(ACT_STORE, 8'h07, 8'h0F, 24'hF0F0F0, 32'h0F0F0F0F, 8'h00);
    queue_item(ACT_DRAIN, 8'h00, 8'h00, 24'h0, 32'h0, 8'h00);
    queue_item(ACT_UNUSED, 8'hFF, 8'hFF, 24'hFFFFFF, 32'hFFFFFFFF, 8'hFF);
    queue_item(ACT_DRAIN, 8'h00, 8'h00, 24'h0, 32'h0, 8'h00);
    queue_item(ACT_STORE, 8'h10, 8'h20, 24'hABCDEF, 32'hC0FFEE00, 8'h00);
    queue_item(ACT_UNUSED, 8'h00, 8'h00, 24'h0, 32'h0, 8'h00);
    queue_item(ACT_STATUS, 8'h12, 8'h34, 24'h0, 32'h0, 8'h56);
    queue_item(ACT_DRAIN, 8'h00, 8'h00, 24'h0, 32'h0, 8'h00);

    // random: mostly store bursts closed by a drain, plus status, stray drains, stray stores and noise
    while (real_items < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 15);
      if (roll < 11) begin
        n = $urandom_range(0, 7);
        repeat (n) pending_items.push_back(random_item(ACT_STORE));
        pending_items.push_back(random_item(ACT_DRAIN));
        real_items += n + 1;
      end else if (roll < 13) begin
        pending_items.push_back(random_item(ACT_STATUS));
        real_items++;
      end else if (roll == 13) begin
        pending_items.push_back(random_item(ACT_DRAIN));
        real_items++;
      end else if (roll == 14) begin
        pending_items.push_back(random_item(ACT_STORE));
        real_items++;
      end else begin
        pending_items.push_back(random_item(ACT_UNUSED));
      end
    end
    pending_items.push_back(random_item(ACT_DRAIN));

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || start || frame_beats_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("covered %0d stores (%0d dropped the oldest), %0d drains (%0d of a full ring)",
             stores, overwrites, drains, full_drains);
    $display("plus %0d status frames and %0d ignored items; %0d beats checked",
             status_frames, ignored, beats_checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/rbhf_pkg.sv
rtl/rbhf_ring.sv
rtl/rbhf_byte_pair.sv
rtl/reading_buffer_hex_framer_top.sv
tb/reading_buffer_hex_framer_top_tb.sv
